FILE: rtl/ptmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ptmt_pkg
// shared types and constants for the page table map / translate core
// ----------------------------------------------------------------------------
package ptmt_pkg;

  localparam int PAGE_NUMBER_BITS_DEF = 10;
  localparam int OFFSET_BITS          = 12;
  localparam int ADDR_BITS            = 32;
  localparam int VPN_BITS             = ADDR_BITS - OFFSET_BITS;
  localparam int COUNT_BITS           = 11;

  localparam logic [ADDR_BITS-1:0] FRAME_MASK = 32'hFFFF_F000;

  typedef logic [1:0] req_t;
  typedef logic [1:0] status_t;

  // request kinds
  localparam req_t REQ_MAP       = 2'd0;
  localparam req_t REQ_TRANSLATE = 2'd1;
  localparam req_t REQ_READ      = 2'd2;
  localparam req_t REQ_REINIT    = 2'd3;

  // result status codes
  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_MISALIGNED = 2'd1;
  localparam status_t ST_RANGE      = 2'd2;

endpackage : ptmt_pkg
`default_nettype wire

FILE: rtl/page_table_map_translate_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_table_map_translate_core
// single-level page table with 4 KiB pages held in one synchronous memory
// ----------------------------------------------------------------------------
// The table holds 2^PAGE_NUMBER_BITS entries of 32 bits (frame in bits 31..12,
// flags in bits 11..0) in one single-port-write memory with a registered
// read. Each accepted item gives exactly one result item. An error, or a map
// with a page count of zero, is answered from the idle state; translate and
// raw read answer after one memory read; a map writes page_count entries and
// a reinit all 2^PAGE_NUMBER_BITS entries before they answer, because the
// memory's single write port takes one entry per cycle. Items are taken one
// at a time. After reset the core writes the identity mapping (flags zero) to
// all 2^PAGE_NUMBER_BITS entries and accepts no item during that time. A
// finished result waits in the output register while the next item is
// already accepted; a further result waits in a holding register.
// ----------------------------------------------------------------------------
module page_table_map_translate_core #(
  parameter int PAGE_NUMBER_BITS = ptmt_pkg::PAGE_NUMBER_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // request channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire ptmt_pkg::req_t              req_type,
  input  wire logic [31:0]                 virt_addr,
  input  wire logic [31:0]                 physical_address,
  input  wire logic [10:0]                 page_count,
  input  wire logic [11:0]                 flags,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ptmt_pkg::status_t                status,
  output logic [31:0]                      read_data
);

  import ptmt_pkg::*;

  localparam int PNB = PAGE_NUMBER_BITS;
  // table depth, wide enough for the vpn + count span check
  localparam logic [VPN_BITS+1:0] DEPTH = (VPN_BITS+2)'(1) << PNB;

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  // table memory
  logic [ADDR_BITS-1:0] table_mem [2**PNB];
  logic [ADDR_BITS-1:0] mem_rdata;
  logic                 mem_we;
  logic [PNB-1:0]       mem_raddr;

  // control and walk registers
  logic [1:0]           state, state_next;
  logic [PNB-1:0]       walk_addr, walk_addr_next;
  logic [VPN_BITS-1:0]  walk_frame, walk_frame_next;
  logic [PNB:0]         walk_left, walk_left_next;
  logic [11:0]          walk_flags, walk_flags_next;
  logic                 walk_reply, walk_reply_next;
  logic                 rd_raw, rd_raw_next;
  logic [11:0]          rd_offset, rd_offset_next;
  status_t              hold_status, hold_status_next;
  logic [31:0]          hold_data, hold_data_next;
  logic                 out_valid_next;
  status_t              status_next;
  logic [31:0]          read_data_next;

  // request decode
  logic [VPN_BITS-1:0]  vpn;
  logic                 va_misaligned;
  logic                 pa_misaligned;
  logic                 vpn_big;
  logic                 span_big;
  logic                 slot_free;
  logic                 do_emit;
  status_t              emit_status;
  logic [31:0]          emit_data;

  assign vpn           = virt_addr[31:OFFSET_BITS];
  assign va_misaligned = |virt_addr[OFFSET_BITS-1:0];
  assign pa_misaligned = |physical_address[OFFSET_BITS-1:0];
  assign vpn_big       = (vpn >> PNB) != '0;
  assign span_big      = ({2'b00, vpn} + (VPN_BITS+2)'(page_count)) > DEPTH;
  assign mem_raddr     = virt_addr[OFFSET_BITS +: PNB];
  assign mem_we        = (state == S_WALK);
  assign in_ready      = (state == S_IDLE);
  // output register can take a new result this cycle
  assign slot_free     = !out_valid || out_ready;

  // memory: at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[walk_addr] <= {walk_frame, walk_flags};
    end
    mem_rdata <= table_mem[mem_raddr];
  end

  always_comb begin
    state_next       = state;
    walk_addr_next   = walk_addr;
    walk_frame_next  = walk_frame;
    walk_left_next   = walk_left;
    walk_flags_next  = walk_flags;
    walk_reply_next  = walk_reply;
    rd_raw_next      = rd_raw;
    rd_offset_next   = rd_offset;
    hold_status_next = hold_status;
    hold_data_next   = hold_data;
    out_valid_next   = out_valid && !out_ready;
    status_next      = status;
    read_data_next   = read_data;
    do_emit          = 1'b0;
    emit_status      = ST_OK;
    emit_data        = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (req_type)
            REQ_MAP: begin
              if (va_misaligned || pa_misaligned) begin
                do_emit     = 1'b1;
                emit_status = ST_MISALIGNED;
              end else if (vpn_big || span_big) begin
                do_emit     = 1'b1;
                emit_status = ST_RANGE;
              end else if (page_count == '0) begin
                do_emit     = 1'b1;
              end else begin
                // walk from the start page, one entry per cycle
                walk_addr_next  = vpn[PNB-1:0];
                walk_frame_next = physical_address[31:OFFSET_BITS];
                walk_left_next  = (PNB+1)'(page_count);
                walk_flags_next = flags;
                walk_reply_next = 1'b1;
                state_next      = S_WALK;
              end
            end
            REQ_TRANSLATE: begin
              if (vpn_big) begin
                do_emit     = 1'b1;
                emit_status = ST_RANGE;
              end else begin
                rd_raw_next    = 1'b0;
                rd_offset_next = virt_addr[OFFSET_BITS-1:0];
                state_next     = S_READ;
              end
            end
            REQ_READ: begin
              if (va_misaligned) begin
                do_emit     = 1'b1;
                emit_status = ST_MISALIGNED;
              end else if (vpn_big) begin
                do_emit     = 1'b1;
                emit_status = ST_RANGE;
              end else begin
                rd_raw_next    = 1'b1;
                rd_offset_next = virt_addr[OFFSET_BITS-1:0];
                state_next     = S_READ;
              end
            end
            REQ_REINIT: begin
              // identity sweep over the whole table
              walk_addr_next  = '0;
              walk_frame_next = '0;
              walk_left_next  = DEPTH[PNB:0];
              walk_flags_next = flags;
              walk_reply_next = 1'b1;
              state_next      = S_WALK;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_WALK: begin
        walk_addr_next  = walk_addr + PNB'(1);
        walk_frame_next = walk_frame + VPN_BITS'(1);
        walk_left_next  = walk_left - (PNB+1)'(1);
        if (walk_left == (PNB+1)'(1)) begin
          if (walk_reply) begin
            do_emit = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_READ: begin
        do_emit = 1'b1;
        if (rd_raw) begin
          emit_data = mem_rdata;
        end else begin
          // frame and offset do not overlap, so the add is an or
          emit_data = (mem_rdata & FRAME_MASK) | {20'h0_0000, rd_offset};
        end
      end
      S_HOLD: begin
        do_emit     = 1'b1;
        emit_status = hold_status;
        emit_data   = hold_data;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // hand a finished result to the output register, or park it
    if (do_emit) begin
      if (slot_free) begin
        out_valid_next = 1'b1;
        status_next    = emit_status;
        read_data_next = emit_data;
        state_next     = S_IDLE;
      end else begin
        hold_status_next = emit_status;
        hold_data_next   = emit_data;
        state_next       = S_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // start with the identity sweep, flags zero, no result
      state      <= S_WALK;
      walk_addr  <= '0;
      walk_frame <= '0;
      walk_left  <= DEPTH[PNB:0];
      walk_flags <= '0;
      walk_reply <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      walk_addr  <= walk_addr_next;
      walk_frame <= walk_frame_next;
      walk_left  <= walk_left_next;
      walk_flags <= walk_flags_next;
      walk_reply <= walk_reply_next;
      out_valid  <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_raw      <= rd_raw_next;
    rd_offset   <= rd_offset_next;
    hold_status <= hold_status_next;
    hold_data   <= hold_data_next;
    status      <= status_next;
    read_data   <= read_data_next;
  end

endmodule : page_table_map_translate_core
`default_nettype wire
